>>> rtl/core/goal_approach_velocity_limiter_assert.svh
// assertion macros for the goal approach velocity limiter
`ifndef GOAL_APPROACH_VELOCITY_LIMITER_ASSERT_SVH
`define GOAL_APPROACH_VELOCITY_LIMITER_ASSERT_SVH

// implication checked on every clock, held off in reset
`define GAVL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off in reset
`define GAVL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gavl_pkg.sv
// ----------------------------------------------------------------------------
// gavl_pkg
// types and constants shared by the goal approach velocity limiter
// ----------------------------------------------------------------------------
package gavl_pkg;

  // result zone codes
  typedef enum logic [1:0] {
    ZONE_PASS   = 2'd0,
    ZONE_SCALED = 2'd1,
    ZONE_DIRECT = 2'd2,
    ZONE_STOP   = 2'd3
  } zone_t;

  // register indexes
  localparam logic [2:0] REG_GOAL_X      = 3'd0;
  localparam logic [2:0] REG_GOAL_Y      = 3'd1;
  localparam logic [2:0] REG_SLOW_DIST   = 3'd2;
  localparam logic [2:0] REG_SPEED_CAP   = 3'd3;
  localparam logic [2:0] REG_DIRECT_DIST = 3'd4;
  localparam logic [2:0] REG_DRIVE_GAIN  = 3'd5;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_W      = 32;
  localparam int VEL_W      = 24;

  // input word
  typedef struct packed {
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic signed [VEL_W-1:0] cmd_vx;
    logic signed [VEL_W-1:0] cmd_vy;
    logic signed [VEL_W-1:0] cmd_wz;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [VEL_W-1:0] out_vx;
    logic signed [VEL_W-1:0] out_vy;
    logic signed [VEL_W-1:0] out_wz;
    logic [1:0]              zone;
  } out_word_t;

endpackage

>>> rtl/core/gavl_stream_if.sv
// ----------------------------------------------------------------------------
// gavl_stream_if
// valid/ready channel carrying one word of type word_t
// ----------------------------------------------------------------------------
interface gavl_stream_if #(
  parameter type word_t = logic
) (
  input logic clk
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/goal_approach_velocity_limiter.sv
// ----------------------------------------------------------------------------
// goal_approach_velocity_limiter
// caps a planar velocity command by its distance to a configured goal
// ----------------------------------------------------------------------------
// A word enters every cycle unless the output stalls; its result passes
// three bit-serial pipelines in a row, the distance root (26 stages), the
// command speed root (25 stages) and the restoring divider for the output
// scaling (26 stages), plus seven stages of differences, squares, sums,
// multiplies and selection. Throughput is one word per cycle while the
// output is not stalled; the whole pipe advances only when its last stage
// can move, so an output stall holds every stage in place. Config writes go
// straight into the registers and are only legal while the pipe is empty.
`include "goal_approach_velocity_limiter_assert.svh"

module goal_approach_velocity_limiter #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gavl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gavl_pkg::CFG_DATA_W-1:0] cfg_data,
  gavl_stream_if.sink                   in_s,
  gavl_stream_if.source                 out_s
);
  import gavl_pkg::*;

  localparam logic [25:0] EPS = 26'((64'd1 << FRAC_BITS) / 64'd100);
  localparam int RD = 26;  // distance root stages (52-bit radicand)
  localparam int RS = 25;  // speed root stages (50-bit radicand)
  localparam int DQ = 26;  // quotient bits of the divider

  // stage numbering
  localparam int S_DIFF = 1;
  localparam int S_SQ   = 2;
  localparam int S_SUM  = 3;
  localparam int D0     = S_SUM;       // distance root starts after this
  localparam int S_DR   = D0 + RD;     // distance ready
  localparam int S_SPD  = S_DR + 1;    // dist*gain
  localparam int S_CL   = S_SPD + 1;   // zone decide, speed clamp
  localparam int R0     = S_CL;        // speed root after this
  localparam int S_SR   = R0 + RS;     // speed root ready
  localparam int S_NUM  = S_SR + 1;    // numerators
  localparam int Q0     = S_NUM;
  localparam int S_Q    = Q0 + DQ;     // quotients ready
  localparam int S_OUT  = S_Q + 1;
  localparam int NST    = S_OUT;

  // config registers
  logic signed [31:0] goal_x, goal_y;
  logic [23:0] slow_dist, direct_dist, gain;
  logic [22:0] cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x      <= '0;
      goal_y      <= '0;
      slow_dist   <= 24'd98304;
      cap         <= 23'd32768;
      direct_dist <= 24'd32768;
      gain        <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GOAL_X:      goal_x      <= cfg_data;
        REG_GOAL_Y:      goal_y      <= cfg_data;
        REG_SLOW_DIST:   slow_dist   <= cfg_data[23:0];
        REG_SPEED_CAP:   cap         <= cfg_data[22:0];
        REG_DIRECT_DIST: direct_dist <= cfg_data[23:0];
        REG_DRIVE_GAIN:  gain        <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic adv;
  logic [NST:1] vld;
  assign adv      = !vld[NST] || out_s.ready;
  assign in_s.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NST-1:1], in_s.valid};
  end

  // side data carried along every stage
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] wz;
    logic               far;
    logic [25:0]        goal_dist;
    logic [1:0]         zone;
    logic [22:0]        spd;
    logic [24:0]        s;
    logic               div;    // divide needed
    logic [25:0]        dvs;    // divisor
    logic [23:0]        dp;     // result when no divide
    logic [23:0]        dq;
    logic [23:0]        dw;
  } side_t;

  side_t sd [1:NST];

  // stage 1: differences
  side_t diff_next;
  always_comb begin
    diff_next    = '0;
    diff_next.dx = 33'(goal_x) - 33'(in_s.data.pose_x);
    diff_next.dy = 33'(goal_y) - 33'(in_s.data.pose_y);
    diff_next.vx = in_s.data.cmd_vx;
    diff_next.vy = in_s.data.cmd_vy;
    diff_next.wz = in_s.data.cmd_wz;
  end

  always_ff @(posedge clk) if (adv) sd[S_DIFF] <= diff_next;

  // stage 2: magnitudes squared (far words get their squares cleared)
  logic [32:0] ax, ay;
  logic [47:0] sqx, sqy;
  logic [23:0] mx, my;
  assign ax = sd[S_DIFF].dx[32] ? 33'(-sd[S_DIFF].dx) : 33'(sd[S_DIFF].dx);
  assign ay = sd[S_DIFF].dy[32] ? 33'(-sd[S_DIFF].dy) : 33'(sd[S_DIFF].dy);
  logic far1;
  assign far1 = |ax[32:24] || |ay[32:24];
  assign mx = sd[S_DIFF].vx[23] ? 24'(-sd[S_DIFF].vx) : 24'(sd[S_DIFF].vx);
  assign my = sd[S_DIFF].vy[23] ? 24'(-sd[S_DIFF].vy) : 24'(sd[S_DIFF].vy);

  side_t sq_next;
  always_comb begin
    sq_next     = sd[S_DIFF];
    sq_next.far = far1;
  end

  logic [47:0] vsx, vsy;
  always_ff @(posedge clk) if (adv) begin
    sd[S_SQ] <= sq_next;
    sqx <= far1 ? '0 : ax[23:0] * ax[23:0];
    sqy <= far1 ? '0 : ay[23:0] * ay[23:0];
    vsx <= mx * mx;
    vsy <= my * my;
  end

  // stage 3: sums
  logic [48:0] rad_d, rad_s3;
  always_ff @(posedge clk) if (adv) begin
    sd[S_SUM] <= sd[S_SQ];
    rad_d  <= 49'(sqx) + 49'(sqy);
    rad_s3 <= 49'(vsx) + 49'(vsy);
  end

  // distance root: one result bit per stage, radicand padded to 52 bits
  logic [51:0] dr_x [0:RD];
  logic [25:0] dr_r [0:RD];
  logic [48:0] vs_c [0:RD+2];  // speed radicand carried along
  assign dr_x[0] = 52'(rad_d);
  assign dr_r[0] = '0;
  assign vs_c[0] = rad_s3;

  for (genvar i = 0; i < RD; i++) begin : g_droot
    localparam int SH = 2 * (RD - 1 - i);
    logic [27:0] trial, rem;
    logic [51:0] x_n;
    logic [25:0] r_n;
    always_comb begin
      rem   = 28'(dr_x[i] >> SH);
      trial = {dr_r[i], 2'b01};
      x_n   = dr_x[i];
      r_n   = {dr_r[i][24:0], 1'b0};
      if (rem >= trial) begin
        x_n = dr_x[i] - (52'(trial) << SH);
        r_n = {dr_r[i][24:0], 1'b1};
      end
    end
    always_ff @(posedge clk) if (adv) begin
      dr_x[i+1]        <= x_n;
      dr_r[i+1]        <= r_n;
      vs_c[i+1]        <= vs_c[i];
      sd[D0+i+1]       <= sd[D0+i];
    end
  end

  // stage S_SPD: distance times gain
  logic [49:0] dg;
  side_t spd_next;
  always_comb begin
    spd_next           = sd[S_DR];
    spd_next.goal_dist = dr_r[RD];
  end

  always_ff @(posedge clk) if (adv) begin
    sd[S_SPD]      <= spd_next;
    dg             <= dr_r[RD] * gain;
    vs_c[RD+1]     <= vs_c[RD];
  end

  // stage S_CL: zone decision and speed clamp
  logic [49:0] dgs;
  logic        in_dir, in_slow;
  assign dgs     = dg >> FRAC_BITS;
  assign in_dir  = !sd[S_SPD].far && sd[S_SPD].goal_dist < 26'(direct_dist);
  assign in_slow = !sd[S_SPD].far && sd[S_SPD].goal_dist < 26'(slow_dist);

  side_t cl_next;
  always_comb begin
    cl_next     = sd[S_SPD];
    cl_next.spd = (dgs > 50'(cap)) ? cap : dgs[22:0];
    if (in_dir)
      cl_next.zone = (sd[S_SPD].goal_dist > EPS) ? ZONE_DIRECT : ZONE_STOP;
    else if (in_slow)
      cl_next.zone = ZONE_SCALED;  // tentative, checked against s
    else
      cl_next.zone = ZONE_PASS;
  end

  always_ff @(posedge clk) if (adv) begin
    sd[S_CL]   <= cl_next;
    vs_c[RD+2] <= vs_c[RD+1];
  end

  // speed root: 50-bit radicand
  logic [49:0] sr_x [0:RS];
  logic [24:0] sr_r [0:RS];
  assign sr_x[0] = 50'(vs_c[RD+2]);
  assign sr_r[0] = '0;

  for (genvar i = 0; i < RS; i++) begin : g_sroot
    localparam int SH = 2 * (RS - 1 - i);
    logic [26:0] trial, rem;
    logic [49:0] x_n;
    logic [24:0] r_n;
    always_comb begin
      rem   = 27'(sr_x[i] >> SH);
      trial = {sr_r[i], 2'b01};
      x_n   = sr_x[i];
      r_n   = {sr_r[i][23:0], 1'b0};
      if (rem >= trial) begin
        x_n = sr_x[i] - (50'(trial) << SH);
        r_n = {sr_r[i][23:0], 1'b1};
      end
    end
    always_ff @(posedge clk) if (adv) begin
      sr_x[i+1]  <= x_n;
      sr_r[i+1]  <= r_n;
      sd[R0+i+1] <= sd[R0+i];
    end
  end

  // stage S_NUM: numerators; signed magnitudes of three products
  logic [24:0] sv;
  logic        scale;
  assign sv    = sr_r[RS];
  assign scale = sd[S_SR].zone == ZONE_SCALED && sv > 25'(cap);

  logic [49:0] num_a, num_b, num_c;
  logic [2:0]  neg;
  logic [32:0] adx, ady;
  logic [23:0] avx, avy, awz;
  assign adx = sd[S_SR].dx[32] ? 33'(-sd[S_SR].dx) : 33'(sd[S_SR].dx);
  assign ady = sd[S_SR].dy[32] ? 33'(-sd[S_SR].dy) : 33'(sd[S_SR].dy);
  assign avx = sd[S_SR].vx[23] ? 24'(-sd[S_SR].vx) : 24'(sd[S_SR].vx);
  assign avy = sd[S_SR].vy[23] ? 24'(-sd[S_SR].vy) : 24'(sd[S_SR].vy);
  assign awz = sd[S_SR].wz[23] ? 24'(-sd[S_SR].wz) : 24'(sd[S_SR].wz);

  side_t       num_sd_next;
  logic [49:0] num_a_next, num_b_next, num_c_next;
  logic [2:0]  neg_next;
  always_comb begin
    num_sd_next     = sd[S_SR];
    num_sd_next.s   = sv;
    num_sd_next.dp  = sd[S_SR].vx;
    num_sd_next.dq  = sd[S_SR].vy;
    num_sd_next.dw  = sd[S_SR].wz;
    num_sd_next.div = 1'b0;
    num_sd_next.dvs = 26'd1;
    num_a_next = '0;
    num_b_next = '0;
    num_c_next = '0;
    neg_next   = '0;
    case (sd[S_SR].zone)
      ZONE_DIRECT: begin
        num_sd_next.div = 1'b1;
        num_sd_next.dvs = sd[S_SR].goal_dist;
        num_a_next = 50'(sd[S_SR].spd) * 50'(adx[23:0]);
        num_b_next = 50'(sd[S_SR].spd) * 50'(ady[23:0]);
        neg_next   = {1'b0, sd[S_SR].dy[32], sd[S_SR].dx[32]};
      end
      ZONE_STOP: begin
        num_sd_next.dp = '0;
        num_sd_next.dq = '0;
        num_sd_next.dw = '0;
      end
      ZONE_SCALED: begin
        if (scale) begin
          num_sd_next.div = 1'b1;
          num_sd_next.dvs = 26'(sv);
          num_a_next = 50'(avx) * 50'(cap);
          num_b_next = 50'(avy) * 50'(cap);
          num_c_next = 50'(awz) * 50'(cap);
          neg_next   = {sd[S_SR].wz[23], sd[S_SR].vy[23], sd[S_SR].vx[23]};
        end else begin
          num_sd_next.zone = ZONE_PASS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) if (adv) begin
    sd[S_NUM] <= num_sd_next;
    num_a <= num_a_next;
    num_b <= num_b_next;
    num_c <= num_c_next;
    neg   <= neg_next;
  end

  // restoring divider: three lanes share the divisor, one quotient bit a stage
  // quotient is known below 2^24, inside the 2^26 that DQ stages cover
  logic [49:0] dv_r [0:DQ][3];
  logic [2:0]  dv_n [0:DQ];
  assign dv_r[0][0] = num_a;
  assign dv_r[0][1] = num_b;
  assign dv_r[0][2] = num_c;
  assign dv_n[0]    = neg;

  for (genvar i = 0; i < DQ; i++) begin : g_div
    localparam int SH = DQ - 1 - i;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [49:0] rr;
      logic [50:0] ds;
      always_comb begin
        ds = 51'(sd[Q0+i].dvs) << SH;
        rr = dv_r[i][l];
        if (51'(dv_r[i][l]) >= ds) rr = dv_r[i][l] - 50'(ds);
      end
      always_ff @(posedge clk) if (adv) dv_r[i+1][l] <= rr;
    end
    always_ff @(posedge clk) if (adv) begin
      dv_n[i+1]  <= dv_n[i];
      sd[Q0+i+1] <= sd[Q0+i];
    end
  end

  // quotients recovered from numerator minus remainder over the divisor is
  // costly, so the quotient bits are collected alongside
  logic [DQ-1:0] qb [0:DQ][3];
  for (genvar l = 0; l < 3; l++) begin : g_q0
    assign qb[0][l] = '0;
  end
  for (genvar i = 0; i < DQ; i++) begin : g_qb
    localparam int SH = DQ - 1 - i;
    for (genvar l = 0; l < 3; l++) begin : g_ql
      logic bitq;
      assign bitq = 51'(dv_r[i][l]) >= (51'(sd[Q0+i].dvs) << SH);
      always_ff @(posedge clk) if (adv) qb[i+1][l] <= {qb[i][l][DQ-2:0], bitq};
    end
  end

  // final stage: apply signs and pick result
  out_word_t res, res_next;
  logic [23:0] q0, q1, q2;
  assign q0 = dv_n[DQ][0] ? 24'(-qb[DQ][0]) : qb[DQ][0][23:0];
  assign q1 = dv_n[DQ][1] ? 24'(-qb[DQ][1]) : qb[DQ][1][23:0];
  assign q2 = dv_n[DQ][2] ? 24'(-qb[DQ][2]) : qb[DQ][2][23:0];

  always_comb begin
    res_next.zone = sd[S_Q].zone;
    if (sd[S_Q].div) begin
      res_next.out_vx = q0;
      res_next.out_vy = q1;
      res_next.out_wz = (sd[S_Q].zone == ZONE_DIRECT) ? '0 : q2;
    end else begin
      res_next.out_vx = sd[S_Q].dp;
      res_next.out_vy = sd[S_Q].dq;
      res_next.out_wz = sd[S_Q].dw;
    end
  end

  always_ff @(posedge clk) if (adv) begin
    sd[S_OUT] <= sd[S_Q];
    res       <= res_next;
  end

  assign out_s.valid = vld[NST];
  assign out_s.data  = res;

  // checks
  `GAVL_ASSERT_NEXT(a_stall_hold, out_s.valid && !out_s.ready,
    out_s.valid && $stable(out_s.data), "stalled result changed")
  `GAVL_ASSERT_IMP(a_ready_adv, !out_s.valid, in_s.ready,
    "input blocked with empty output")
  `GAVL_ASSERT_IMP(a_stop_zero, out_s.valid && res.zone == ZONE_STOP,
    res.out_vx == '0 && res.out_vy == '0 && res.out_wz == '0, "stop not zero")
  `GAVL_ASSERT_IMP(a_direct_wz, out_s.valid && res.zone == ZONE_DIRECT,
    res.out_wz == '0, "direct drive with yaw rate")

endmodule
